// ===== hw/rtl/lci_pkg.sv =====
`timescale 1ns / 1ps

package lci_pkg;

   // Default sizes of the classifier
   localparam int FEATURES_DEF    = 784;
   localparam int CLASSES_DEF     = 10;
   localparam int WEIGHT_BITS_DEF = 16;
   localparam int ACC_BITS_DEF    = 40;

   // Fixed field widths on the stream ports
   localparam int FEAT_W  = 10;
   localparam int CLASS_W = 4;
   localparam int WVAL_W  = 16;
   localparam int PIXEL_W = 8;
   localparam int SCORE_W = 40;

   // Request tdata layout, lowest field first
   localparam int REQ_FEAT_LSB  = 0;
   localparam int REQ_CLASS_LSB = REQ_FEAT_LSB + FEAT_W;
   localparam int REQ_WVAL_LSB  = REQ_CLASS_LSB + CLASS_W;
   localparam int REQ_PIXEL_LSB = REQ_WVAL_LSB + WVAL_W;
   localparam int REQ_USED_W    = REQ_PIXEL_LSB + PIXEL_W;
   localparam int REQ_DATA_W    = ((REQ_USED_W + 7) / 8) * 8;

   // Response tdata layout, lowest field first
   localparam int RSP_USED_W = CLASS_W + SCORE_W;
   localparam int RSP_DATA_W = ((RSP_USED_W + 7) / 8) * 8;

   // Result queue depth, covers every result the pipeline can hold
   localparam int RSP_DEPTH = 16;

   // Request kinds carried on req_tuser
   typedef enum logic {
      OP_WEIGHT = 1'b0,
      OP_PIXEL  = 1'b1
   } lci_op_type;

   // Control that travels beside a pixel through the pipeline
   typedef struct packed {
      logic valid;
      logic add;
      logic last;
   } lci_ctrl_type;

endpackage

// ===== hw/rtl/linear_classifier_inference_top.sv =====
`timescale 1ns / 1ps
// A last pixel accepted on the request port passes the weight read, the multiply, the accumulate,
// the argmax tree levels and the queue write before rsp_tvalid rises.
// Throughput: one request per cycle, weight write or pixel, set by one read or write port per
// class lane memory. req_tready drops only while 16 results are queued or in flight.
// Reset clears the accumulators, the pipeline valids and the result queue; the weight store
// is not cleared and must be written before a pixel reads it.

module linear_classifier_inference_top import lci_pkg::*; #(
   parameter int FEATURES    = FEATURES_DEF,
   parameter int CLASSES     = CLASSES_DEF,
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
   parameter int ACC_BITS    = ACC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // feature_index[9:0], class_index[13:10], weight_value[29:14], pixel[37:30], zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // opcode
   input  logic                  req_tuser,
   // last_pixel
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // predicted_class[3:0], best_score[43:4], zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int ADDR_W = (FEATURES > 1) ? $clog2(FEATURES) : 1;
   localparam int PROD_W = WEIGHT_BITS + PIXEL_W + 1;
   localparam int IDX_W  = $clog2(CLASSES);
   localparam int OCC_W  = $clog2(RSP_DEPTH + 1);

   logic [FEAT_W-1:0]  req_feature_index;
   logic [CLASS_W-1:0] req_class_index;
   logic [WVAL_W-1:0]  req_weight_value;
   logic [PIXEL_W-1:0] req_pixel;
   logic               req_accept;
   logic               rsp_accept;
   logic               is_pixel;
   logic               feat_ok;
   logic               cls_ok;
   logic [ADDR_W-1:0]  mem_addr;

   lci_ctrl_type       s1_ctrl_ff;
   lci_ctrl_type       s1_ctrl_in;
   lci_ctrl_type       s2_ctrl_ff;
   logic [PIXEL_W-1:0] s1_pixel_ff;

   logic signed [PROD_W-1:0] lane_prod [CLASSES];
   logic                     snap_vld;
   logic [ACC_BITS-1:0]      snap_score [CLASSES];
   logic                     win_vld;
   logic [IDX_W-1:0]         win_idx;
   logic [ACC_BITS-1:0]      win_score;
   logic [RSP_USED_W-1:0]    fifo_data;

   logic [OCC_W-1:0] occ_ff;
   logic [OCC_W-1:0] occ_in;
   logic             res_inc;

   // Unpack the request
   assign req_feature_index = req_tdata[REQ_FEAT_LSB +: FEAT_W];
   assign req_class_index   = req_tdata[REQ_CLASS_LSB +: CLASS_W];
   assign req_weight_value  = req_tdata[REQ_WVAL_LSB +: WVAL_W];
   assign req_pixel         = req_tdata[REQ_PIXEL_LSB +: PIXEL_W];

   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_tvalid && rsp_tready;
   assign is_pixel   = lci_op_type'(req_tuser) == OP_PIXEL;
   assign feat_ok    = int'(req_feature_index) < FEATURES;
   assign cls_ok     = int'(req_class_index) < CLASSES;
   assign mem_addr   = ADDR_W'(req_feature_index);

   // Reserve a result slot for every last pixel taken in
   assign res_inc    = req_accept && is_pixel && req_tlast;
   assign occ_in     = occ_ff + OCC_W'(res_inc) - OCC_W'(rsp_accept);
   assign req_tready = occ_ff != OCC_W'(RSP_DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   // Carry pixel control beside the weight read and the products
   always_comb begin
      s1_ctrl_in.valid = req_accept && is_pixel;
      s1_ctrl_in.add   = feat_ok;
      s1_ctrl_in.last  = req_tlast;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctrl_ff <= '0;
         s2_ctrl_ff <= '0;
      end else begin
         s1_ctrl_ff <= s1_ctrl_in;
         s2_ctrl_ff <= s1_ctrl_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_pixel_ff <= req_pixel;
   end

   // One weight memory and multiplier per class
   for (genvar k = 0; k < CLASSES; k++) begin : g_lane
      logic wr_en;
      assign wr_en = req_accept && !is_pixel && feat_ok && cls_ok &&
                     (req_class_index == CLASS_W'(k));

      lci_lane #(
         .FEATURES    (FEATURES),
         .WEIGHT_BITS (WEIGHT_BITS)
      ) u_lane (
         .clock   (clock),
         .wr_en   (wr_en),
         .rd_en   (s1_ctrl_in.valid),
         .addr    (mem_addr),
         .wr_data (WEIGHT_BITS'(req_weight_value)),
         .pixel   (s1_pixel_ff),
         .prod    (lane_prod[k])
      );
   end

   lci_accum #(
      .CLASSES     (CLASSES),
      .WEIGHT_BITS (WEIGHT_BITS),
      .ACC_BITS    (ACC_BITS)
   ) u_accum (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (s2_ctrl_ff),
      .prod       (lane_prod),
      .snap_vld   (snap_vld),
      .snap_score (snap_score)
   );

   lci_argmax #(
      .CLASSES  (CLASSES),
      .ACC_BITS (ACC_BITS)
   ) u_argmax (
      .clock     (clock),
      .reset     (reset),
      .in_vld    (snap_vld),
      .in_score  (snap_score),
      .out_vld   (win_vld),
      .out_idx   (win_idx),
      .out_score (win_score)
   );

   // Queue finished results until the response side takes them
   lci_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (win_vld),
      .push_data ({SCORE_W'(win_score), CLASS_W'(win_idx)}),
      .pop       (rsp_tready),
      .out_vld   (rsp_tvalid),
      .out_data  (fifo_data)
   );

   assign rsp_tdata = {(RSP_DATA_W - RSP_USED_W)'(0), fifo_data};

   // Reservations never exceed the queue depth
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(RSP_DEPTH))
      else $error("result reservations exceed queue depth");

   // A queued result always holds a reservation
   a_rsp_reserved: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> occ_ff != '0)
      else $error("response valid without a reservation");

   // A finished argmax always has a reserved slot to land in
   a_win_reserved: assert property (@(posedge clock) disable iff (reset)
      win_vld |-> occ_ff != '0)
      else $error("argmax result without a reservation");

   // A snapshot is taken only on a last pixel, where the accumulators start a new image
   a_acc_cleared: assert property (@(posedge clock) disable iff (reset)
      snap_vld |-> $past(s2_ctrl_ff.valid) && $past(s2_ctrl_ff.last))
      else $error("snapshot without a last pixel");

endmodule

// ===== hw/rtl/lci_lane.sv =====
`timescale 1ns / 1ps

module lci_lane import lci_pkg::*; #(
   parameter int FEATURES    = FEATURES_DEF,
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
   localparam int ADDR_W     = (FEATURES > 1) ? $clog2(FEATURES) : 1,
   localparam int PROD_W     = WEIGHT_BITS + PIXEL_W + 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [ADDR_W-1:0]        addr,
   input  logic [WEIGHT_BITS-1:0]   wr_data,
   input  logic [PIXEL_W-1:0]       pixel,
   output logic signed [PROD_W-1:0] prod
);

   logic [WEIGHT_BITS-1:0]   mem [FEATURES];
   logic [WEIGHT_BITS-1:0]   rd_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   // Weight column of this class, one port per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[addr];
      end
   end

   // Multiply the unsigned pixel by the signed weight
   assign prod_in = PROD_W'($signed({1'b0, pixel})) * PROD_W'($signed(rd_ff));

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ===== hw/rtl/lci_accum.sv =====
`timescale 1ns / 1ps

module lci_accum import lci_pkg::*; #(
   parameter int CLASSES     = CLASSES_DEF,
   parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
   parameter int ACC_BITS    = ACC_BITS_DEF,
   localparam int PROD_W     = WEIGHT_BITS + PIXEL_W + 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  lci_ctrl_type             ctrl,
   input  logic signed [PROD_W-1:0] prod [CLASSES],
   output logic                     snap_vld,
   output logic [ACC_BITS-1:0]      snap_score [CLASSES]
);

   logic [ACC_BITS-1:0] acc_ff  [CLASSES];
   logic [ACC_BITS-1:0] sum     [CLASSES];
   logic [ACC_BITS-1:0] snap_ff [CLASSES];
   logic                snap_vld_ff;

   // Add this pixel's products, wrapping at the accumulator width
   always_comb begin
      for (int k = 0; k < CLASSES; k++) begin
         sum[k] = (ctrl.valid && ctrl.add) ? acc_ff[k] + ACC_BITS'(prod[k]) : acc_ff[k];
      end
   end

   // Advance the accumulators; on the last pixel take a snapshot and clear
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CLASSES; k++) begin
            acc_ff[k] <= '0;
         end
         snap_vld_ff <= 1'b0;
      end else begin
         snap_vld_ff <= ctrl.valid && ctrl.last;
         if (ctrl.valid) begin
            for (int k = 0; k < CLASSES; k++) begin
               acc_ff[k] <= ctrl.last ? '0 : sum[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.valid && ctrl.last) begin
         for (int k = 0; k < CLASSES; k++) begin
            snap_ff[k] <= sum[k];
         end
      end
   end

   assign snap_vld   = snap_vld_ff;
   assign snap_score = snap_ff;

endmodule

// ===== hw/rtl/lci_argmax.sv =====
`timescale 1ns / 1ps

module lci_argmax import lci_pkg::*; #(
   parameter int CLASSES  = CLASSES_DEF,
   parameter int ACC_BITS = ACC_BITS_DEF,
   localparam int LEVELS  = $clog2(CLASSES),
   localparam int IDX_W   = LEVELS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_vld,
   input  logic [ACC_BITS-1:0] in_score [CLASSES],
   output logic                out_vld,
   output logic [IDX_W-1:0]    out_idx,
   output logic [ACC_BITS-1:0] out_score
);

   // Tree level l sits in element l-1 of the registers
   logic                vld_ff   [LEVELS];
   logic [ACC_BITS-1:0] score_ff [LEVELS][CLASSES];
   logic [IDX_W-1:0]    idx_ff   [LEVELS][CLASSES];

   logic                lvl_vld   [LEVELS+1];
   logic [ACC_BITS-1:0] lvl_score [LEVELS+1][CLASSES];
   logic [IDX_W-1:0]    lvl_idx   [LEVELS+1][CLASSES];

   logic [ACC_BITS-1:0] score_in [LEVELS][CLASSES];
   logic [IDX_W-1:0]    idx_in   [LEVELS][CLASSES];

   // Gather every level, the leaves straight from the snapshot
   always_comb begin
      lvl_vld[0] = in_vld;
      for (int i = 0; i < CLASSES; i++) begin
         lvl_score[0][i] = in_score[i];
         lvl_idx[0][i]   = IDX_W'(i);
      end
      for (int l = 1; l <= LEVELS; l++) begin
         lvl_vld[l]   = vld_ff[l-1];
         lvl_score[l] = score_ff[l-1];
         lvl_idx[l]   = idx_ff[l-1];
      end
   end

   // Pair up nodes; the left one holds lower indices and wins a tie
   always_comb begin
      int np;
      int a;
      int b;
      for (int l = 0; l < LEVELS; l++) begin
         np = (CLASSES + (1 << l) - 1) >> l;
         for (int i = 0; i < CLASSES; i++) begin
            a = (2 * i < np) ? 2 * i : i;
            b = (2 * i + 1 < np) ? 2 * i + 1 : a;
            if ($signed(lvl_score[l][b]) > $signed(lvl_score[l][a])) begin
               score_in[l][i] = lvl_score[l][b];
               idx_in[l][i]   = lvl_idx[l][b];
            end else begin
               score_in[l][i] = lvl_score[l][a];
               idx_in[l][i]   = lvl_idx[l][a];
            end
         end
      end
   end

   // Register one tree level per stage
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < LEVELS; l++) begin
            vld_ff[l] <= 1'b0;
         end
      end else begin
         for (int l = 0; l < LEVELS; l++) begin
            vld_ff[l] <= lvl_vld[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      score_ff <= score_in;
      idx_ff   <= idx_in;
   end

   assign out_vld   = lvl_vld[LEVELS];
   assign out_idx   = lvl_idx[LEVELS][0];
   assign out_score = lvl_score[LEVELS][0];

endmodule

// ===== hw/rtl/lci_rsp_fifo.sv =====
`timescale 1ns / 1ps

module lci_rsp_fifo import lci_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [RSP_USED_W-1:0] push_data,
   input  logic                  pop,
   output logic                  out_vld,
   output logic [RSP_USED_W-1:0] out_data
);

   localparam int PTR_W = $clog2(RSP_DEPTH);
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   logic [RSP_USED_W-1:0] slot_ff [RSP_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff;
   logic [PTR_W-1:0]      rd_ptr_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [PTR_W-1:0]      wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_in;
   logic [CNT_W-1:0]      count_in;
   logic                  do_pop;

   assign do_pop = pop && (count_ff != '0);

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(RSP_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(RSP_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_vld  = count_ff != '0;
   assign out_data = slot_ff[rd_ptr_ff];

endmodule
